// File: rtl/core/clx_pkg.sv
// clx_pkg: shared types, constants and character helpers of the c source lexer
// depends on nothing; imported by every module of the lexer
`default_nettype none

package clx_pkg;

    // default geometry of the position counters
    localparam int DEF_ROW_WIDTH = 16;
    localparam int DEF_COL_WIDTH = 12;

    // result field widths
    localparam int KIND_W     = 4;
    localparam int KW_W       = 5;
    localparam int OUT_ROW_W  = 16;
    localparam int OUT_COL_W  = 12;
    localparam int LEN_W      = 12;
    localparam int TDATA_IN_W = 8;
    localparam int TDATA_OUT_W = 56;

    // keyword table geometry
    localparam int KW_COUNT   = 32;
    localparam int KW_MAX_LEN = 8;
    localparam int KW_BUF_W   = 8 * KW_MAX_LEN;

    // result queue depth
    localparam int FIFO_DEPTH = 4;

    // token kinds
    localparam logic [KIND_W-1:0] KIND_ARITH      = 4'd0;
    localparam logic [KIND_W-1:0] KIND_RELATIONAL = 4'd1;
    localparam logic [KIND_W-1:0] KIND_LOGICAL    = 4'd2;
    localparam logic [KIND_W-1:0] KIND_SPECIAL    = 4'd3;
    localparam logic [KIND_W-1:0] KIND_KEYWORD    = 4'd4;
    localparam logic [KIND_W-1:0] KIND_NUMBER     = 4'd5;
    localparam logic [KIND_W-1:0] KIND_STRING     = 4'd6;
    localparam logic [KIND_W-1:0] KIND_IDENT      = 4'd7;
    localparam logic [KIND_W-1:0] KIND_SHORTHAND  = 4'd8;
    localparam logic [KIND_W-1:0] KIND_ASSIGN     = 4'd9;

    // characters with a meaning to the lexer
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_UNDER   = 8'h5F;

    // one result word
    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [KW_W-1:0]      kw;
        logic [OUT_ROW_W-1:0] row;
        logic [OUT_COL_W-1:0] col;
        logic [LEN_W-1:0]     len;
        logic                 last;
    } t_result;

    // up to two result words from one input word, b only when a
    typedef struct packed {
        logic    a_valid;
        logic    b_valid;
        t_result a;
        t_result b;
    } t_push;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    // keyword text, first character in the highest used byte
    function automatic logic [KW_BUF_W-1:0] kw_word(input logic [KW_W-1:0] idx);
        logic [KW_BUF_W-1:0] w;
        begin
            unique case (idx)
                5'd0:  w = 64'("auto");
                5'd1:  w = 64'("break");
                5'd2:  w = 64'("case");
                5'd3:  w = 64'("char");
                5'd4:  w = 64'("continue");
                5'd5:  w = 64'("do");
                5'd6:  w = 64'("default");
                5'd7:  w = 64'("const");
                5'd8:  w = 64'("double");
                5'd9:  w = 64'("else");
                5'd10: w = 64'("enum");
                5'd11: w = 64'("extern");
                5'd12: w = 64'("for");
                5'd13: w = 64'("if");
                5'd14: w = 64'("goto");
                5'd15: w = 64'("float");
                5'd16: w = 64'("int");
                5'd17: w = 64'("long");
                5'd18: w = 64'("register");
                5'd19: w = 64'("return");
                5'd20: w = 64'("signed");
                5'd21: w = 64'("static");
                5'd22: w = 64'("sizeof");
                5'd23: w = 64'("short");
                5'd24: w = 64'("struct");
                5'd25: w = 64'("switch");
                5'd26: w = 64'("typedef");
                5'd27: w = 64'("union");
                5'd28: w = 64'("void");
                5'd29: w = 64'("while");
                5'd30: w = 64'("volatile");
                5'd31: w = 64'("unsigned");
            endcase
            return w;
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/clx_lex_core.sv
// clx_lex_core: input word register, lexer state and one-step token logic
// depends on clx_pkg; feeds result words to clx_out_fifo
`default_nettype none

module clx_lex_core
    import clx_pkg::*;
#(
    parameter int ROW_WIDTH = DEF_ROW_WIDTH,
    parameter int COL_WIDTH = DEF_COL_WIDTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_char,
    input  wire logic       i_end,
    input  wire logic       i_room,
    output t_push           o_push
);

    // lexer modes
    localparam logic [3:0] M_IDLE      = 4'd0;
    localparam logic [3:0] M_IDENT     = 4'd1;
    localparam logic [3:0] M_NUMBER    = 4'd2;
    localparam logic [3:0] M_OPARITH   = 4'd3;
    localparam logic [3:0] M_OPREL     = 4'd4;
    localparam logic [3:0] M_SLASH     = 4'd5;
    localparam logic [3:0] M_STRING    = 4'd6;
    localparam logic [3:0] M_LINECMT   = 4'd7;
    localparam logic [3:0] M_BLOCK     = 4'd8;
    localparam logic [3:0] M_BLOCKSTAR = 4'd9;
    localparam logic [3:0] M_HASH      = 4'd10;

    // input word register
    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_end;

    // lexer state
    logic [3:0]          r_mode,    n_mode;
    logic [KW_BUF_W-1:0] r_kw,      n_kw;
    logic [7:0]          r_pend,    n_pend;
    logic [ROW_WIDTH-1:0] r_row,    n_row;
    logic [COL_WIDTH-1:0] r_col,    n_col;
    logic [ROW_WIDTH-1:0] r_tok_row, n_tok_row;
    logic [COL_WIDTH-1:0] r_tok_col, n_tok_col;
    logic [LEN_W-1:0]    r_len,     n_len;

    logic                 fire;
    logic [ROW_WIDTH-1:0] row_inc;
    logic [COL_WIDTH-1:0] col_inc;
    logic [LEN_W-1:0]     len_inc;
    logic [31:0]          tok_row_w, cur_row_w;
    logic [15:0]          tok_col_w, cur_col_w;
    logic                 kw_hit;
    logic [KW_W-1:0]      kw_idx;
    logic                 has_pend;
    logic [KIND_W-1:0]    pend_kind;
    logic [KW_W-1:0]      pend_kw;
    logic [LEN_W-1:0]     pend_len;
    logic                 emit0, emit1, go_idle;
    logic [KIND_W-1:0]    kind0;
    logic [KW_W-1:0]      kw0;
    logic [LEN_W-1:0]     len0;
    logic                 ident_ch;
    t_result              res0, res1;

    assign fire    = r_in_valid & i_room;
    assign o_ready = ~r_in_valid | fire;

    // saturating counters
    assign row_inc = (r_row == '1) ? r_row : r_row + 1'b1;
    assign col_inc = (r_col == '1) ? r_col : r_col + 1'b1;
    assign len_inc = (r_len == '1) ? r_len : r_len + 1'b1;

    // positions widened for the fixed result fields
    assign tok_row_w = 32'(r_tok_row);
    assign cur_row_w = 32'(r_row);
    assign tok_col_w = 16'(r_tok_col);
    assign cur_col_w = 16'(r_col);

    assign ident_ch = is_alpha(r_in_char) | is_digit(r_in_char) | (r_in_char == CH_UNDER);

    // keyword compare against all entries in parallel
    always_comb begin
        kw_hit = 1'b0;
        kw_idx = '0;
        for (int i = 0; i < KW_COUNT; i++) begin
            if (r_kw == kw_word(KW_W'(i))) begin
                kw_hit = 1'b1;
                kw_idx = KW_W'(i);
            end
        end
    end

    // what the pending token turns into when something ends it
    always_comb begin
        has_pend  = 1'b1;
        pend_kind = KIND_ARITH;
        pend_kw   = '0;
        pend_len  = LEN_W'(1);
        unique case (r_mode)
            M_IDENT: begin
                pend_len = r_len;
                if (kw_hit && r_len <= LEN_W'(KW_MAX_LEN)) begin
                    pend_kind = KIND_KEYWORD;
                    pend_kw   = kw_idx;
                end else begin
                    pend_kind = KIND_IDENT;
                end
            end
            M_NUMBER: begin
                pend_kind = KIND_NUMBER;
                pend_len  = r_len;
            end
            M_OPREL: begin
                if (r_pend == CH_BANG) pend_kind = KIND_LOGICAL;
                else if (r_pend == CH_EQ) pend_kind = KIND_ASSIGN;
                else pend_kind = KIND_RELATIONAL;
            end
            M_OPARITH, M_SLASH: pend_kind = KIND_ARITH;
            default: has_pend = 1'b0;
        endcase
    end

    // one lexer step for the registered word
    always_comb begin
        n_mode    = r_mode;
        n_kw      = r_kw;
        n_pend    = r_pend;
        n_row     = r_row;
        n_col     = r_col;
        n_tok_row = r_tok_row;
        n_tok_col = r_tok_col;
        n_len     = r_len;
        emit0     = 1'b0;
        emit1     = 1'b0;
        go_idle   = 1'b0;
        kind0     = pend_kind;
        kw0       = pend_kw;
        len0      = pend_len;

        if (r_in_end) begin
            emit0  = has_pend;
            n_mode = M_IDLE;
        end else begin
            unique case (r_mode)
                M_IDENT: begin
                    if (ident_ch) begin
                        if (r_len < LEN_W'(KW_MAX_LEN)) n_kw = {r_kw[KW_BUF_W-9:0], r_in_char};
                        n_len = len_inc;
                        n_col = col_inc;
                    end else begin
                        emit0   = 1'b1;
                        go_idle = 1'b1;
                    end
                end
                M_NUMBER: begin
                    if (is_digit(r_in_char) || r_in_char == CH_DOT) begin
                        n_len = len_inc;
                        n_col = col_inc;
                    end else begin
                        emit0   = 1'b1;
                        go_idle = 1'b1;
                    end
                end
                M_OPARITH, M_OPREL: begin
                    if (r_in_char == CH_EQ) begin
                        n_col  = col_inc;
                        emit0  = 1'b1;
                        kind0  = (r_mode == M_OPREL) ? KIND_RELATIONAL : KIND_SHORTHAND;
                        kw0    = '0;
                        len0   = LEN_W'(2);
                        n_mode = M_IDLE;
                    end else begin
                        emit0   = 1'b1;
                        go_idle = 1'b1;
                    end
                end
                M_SLASH: begin
                    if (r_in_char == CH_EQ) begin
                        n_col  = col_inc;
                        emit0  = 1'b1;
                        kind0  = KIND_SHORTHAND;
                        kw0    = '0;
                        len0   = LEN_W'(2);
                        n_mode = M_IDLE;
                    end else if (r_in_char == CH_STAR) begin
                        n_col  = col_inc;
                        n_mode = M_BLOCK;
                    end else if (r_in_char == CH_SLASH) begin
                        n_col  = col_inc;
                        n_mode = M_LINECMT;
                    end else begin
                        emit0   = 1'b1;
                        go_idle = 1'b1;
                    end
                end
                M_STRING, M_LINECMT, M_HASH, M_BLOCK, M_BLOCKSTAR: begin
                    // every byte inside counts toward row and column
                    if (r_in_char == CH_NL) begin
                        n_row = row_inc;
                        n_col = '0;
                    end else begin
                        n_col = col_inc;
                    end
                    if (r_mode == M_STRING) begin
                        n_len = len_inc;
                        if (r_in_char == CH_QUOTE) begin
                            emit0  = 1'b1;
                            kind0  = KIND_STRING;
                            kw0    = '0;
                            len0   = len_inc;
                            n_mode = M_IDLE;
                        end
                    end else if (r_mode == M_BLOCK) begin
                        if (r_in_char == CH_STAR) n_mode = M_BLOCKSTAR;
                    end else if (r_mode == M_BLOCKSTAR) begin
                        if (r_in_char == CH_SLASH) n_mode = M_IDLE;
                        else if (r_in_char != CH_STAR) n_mode = M_BLOCK;
                    end else begin
                        if (r_in_char == CH_NL) n_mode = M_IDLE;
                    end
                end
                default: go_idle = 1'b1;
            endcase

            // lex the byte from idle, after any pending token went out
            if (go_idle) begin
                n_mode = M_IDLE;
                if (r_in_char == CH_NL) begin
                    n_row = row_inc;
                    n_col = '0;
                end else if (r_in_char == CH_SPACE || r_in_char == CH_TAB) begin
                    n_col = col_inc;
                end else if (r_in_char == CH_HASH) begin
                    n_col  = col_inc;
                    n_mode = M_HASH;
                end else begin
                    n_tok_row = r_row;
                    n_tok_col = r_col;
                    n_col     = col_inc;
                    if (r_in_char == CH_SLASH) begin
                        n_mode = M_SLASH;
                    end else if (r_in_char == CH_PLUS || r_in_char == CH_MINUS
                                 || r_in_char == CH_STAR || r_in_char == CH_PERCENT) begin
                        n_mode = M_OPARITH;
                    end else if (r_in_char == CH_LT || r_in_char == CH_GT
                                 || r_in_char == CH_BANG || r_in_char == CH_EQ) begin
                        n_mode = M_OPREL;
                    end else if (is_alpha(r_in_char) || r_in_char == CH_UNDER) begin
                        n_mode = M_IDENT;
                    end else if (is_digit(r_in_char)) begin
                        n_mode = M_NUMBER;
                    end else if (r_in_char == CH_QUOTE) begin
                        n_mode = M_STRING;
                    end else begin
                        emit1 = 1'b1;
                    end
                    if (!emit1) begin
                        n_pend = r_in_char;
                        n_len  = LEN_W'(1);
                        n_kw   = KW_BUF_W'(r_in_char);
                    end
                end
            end
        end
    end

    // result words: ended token first, then a special symbol
    always_comb begin
        res0.kind = kind0;
        res0.kw   = kw0;
        res0.row  = tok_row_w[OUT_ROW_W-1:0];
        res0.col  = tok_col_w[OUT_COL_W-1:0];
        res0.len  = len0;
        res0.last = ~emit1;

        res1.kind = KIND_SPECIAL;
        res1.kw   = '0;
        res1.row  = cur_row_w[OUT_ROW_W-1:0];
        res1.col  = cur_col_w[OUT_COL_W-1:0];
        res1.len  = LEN_W'(1);
        res1.last = 1'b1;

        o_push.a_valid = fire & (emit0 | emit1);
        o_push.b_valid = fire & emit0 & emit1;
        o_push.a       = emit0 ? res0 : res1;
        o_push.b       = res1;
    end

    // input word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_in_char <= i_char;
            r_in_end  <= i_end;
        end
    end

    // lexer state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= M_IDLE;
            r_kw      <= '0;
            r_pend    <= '0;
            r_row     <= ROW_WIDTH'(1);
            r_col     <= '0;
            r_tok_row <= ROW_WIDTH'(1);
            r_tok_col <= '0;
            r_len     <= '0;
        end else if (fire) begin
            r_mode    <= n_mode;
            r_kw      <= n_kw;
            r_pend    <= n_pend;
            r_row     <= n_row;
            r_col     <= n_col;
            r_tok_row <= n_tok_row;
            r_tok_col <= n_tok_col;
            r_len     <= n_len;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/clx_out_fifo.sv
// clx_out_fifo: small result queue taking up to two words per cycle
// depends on clx_pkg; drives the output stream of the lexer
`default_nettype none

module clx_out_fifo
    import clx_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_push i_push,
    output logic       o_room,
    output logic       o_valid,
    output t_result    o_data,
    input  wire logic  i_ready
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    t_result            r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   r_wr, n_wr;
    logic [PTR_W-1:0]   r_rd, n_rd;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               pop;
    logic [CNT_W-1:0]   push_n;
    logic [CNT_W-1:0]   after_pop;
    logic [PTR_W-1:0]   wr_b;

    assign o_valid   = (r_cnt != '0);
    assign o_data    = r_mem[r_rd];
    assign pop       = o_valid & i_ready;
    assign push_n    = CNT_W'(i_push.a_valid) + CNT_W'(i_push.b_valid);
    assign after_pop = r_cnt - CNT_W'(pop);
    // room for a full pair once this cycle's word leaves
    assign o_room    = (after_pop <= CNT_W'(FIFO_DEPTH - 2));
    assign wr_b      = r_wr + 1'b1;

    // pointer and count
    always_comb begin
        n_wr  = r_wr + PTR_W'(push_n);
        n_rd  = r_rd + PTR_W'(pop);
        n_cnt = after_pop + push_n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push.a_valid) r_mem[r_wr] <= i_push.a;
        if (i_push.b_valid) r_mem[wr_b] <= i_push.b;
    end

endmodule

`default_nettype wire

// File: rtl/core/c_source_lexer_unit.sv
// c_source_lexer_unit: streaming c source lexer, one character word per cycle while the result queue has room
// a result word passes through the input word register and then the result queue before it is valid
// throughput: one input word per cycle while the result queue has room; a word ending a token
// and starting a special symbol yields two result words, which are given out one after the other
// reset: synchronous, active low; mode idle, row 1, column 0, queue empty
// depends on clx_pkg, clx_lex_core and clx_out_fifo
`default_nettype none

module c_source_lexer_unit
    import clx_pkg::*;
#(
    parameter int ROW_WIDTH = DEF_ROW_WIDTH,
    parameter int COL_WIDTH = DEF_COL_WIDTH
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // input stream
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  wire logic [TDATA_IN_W-1:0]  i_s_axis_tdata,  // [7:0] character
    input  wire logic                   i_s_axis_tlast,  // end of input
    // result stream
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    // [3:0] token_kind, [8:4] keyword_number, [24:9] start_row,
    // [36:25] start_col, [48:37] token_length, [55:49] zero
    output logic [TDATA_OUT_W-1:0]      o_m_axis_tdata,
    output logic                        o_m_axis_tlast   // last result of the word
);

    t_push   push;
    logic    room;
    t_result res;

    // lexer step
    clx_lex_core #(
        .ROW_WIDTH (ROW_WIDTH),
        .COL_WIDTH (COL_WIDTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_char  (i_s_axis_tdata),
        .i_end   (i_s_axis_tlast),
        .i_room  (room),
        .o_push  (push)
    );

    // result queue
    clx_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_m_axis_tvalid),
        .o_data  (res),
        .i_ready (i_m_axis_tready)
    );

    // output word packing
    assign o_m_axis_tdata = {7'b0, res.len, res.col, res.row, res.kw, res.kind};
    assign o_m_axis_tlast = res.last;

endmodule

`default_nettype wire
